// ===== rtl/wms_pkg.sv =====
// shared types, constants and base coding for the window minimizer select block
`default_nettype none

package wms_pkg;

   localparam int BASE_W     = 8;
   localparam int KLEN_W     = 5;
   localparam int WSIZE_W    = 7;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int KMER_W     = 42;
   localparam int POS_W      = 32;
   localparam int RANK_W     = 3;
   localparam int CODE_W     = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_KMER_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b1;

   // sequence bytes
   localparam logic [BASE_W-1:0] ASCII_A = 8'h41;
   localparam logic [BASE_W-1:0] ASCII_C = 8'h43;
   localparam logic [BASE_W-1:0] ASCII_G = 8'h47;
   localparam logic [BASE_W-1:0] ASCII_T = 8'h54;

   // rank order a < c < g < n < t
   localparam logic [RANK_W-1:0] RANK_A = 3'd0;
   localparam logic [RANK_W-1:0] RANK_C = 3'd1;
   localparam logic [RANK_W-1:0] RANK_G = 3'd2;
   localparam logic [RANK_W-1:0] RANK_N = 3'd3;
   localparam logic [RANK_W-1:0] RANK_T = 3'd4;

   // packed two-bit base codes
   localparam logic [CODE_W-1:0] CODE_A = 2'd0;
   localparam logic [CODE_W-1:0] CODE_C = 2'd1;
   localparam logic [CODE_W-1:0] CODE_G = 2'd2;
   localparam logic [CODE_W-1:0] CODE_T = 2'd3;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_RUN,
      SCAN_LOAD
   } scan_state_type;

   function automatic logic [RANK_W-1:0] base_rank(input logic [BASE_W-1:0] b);
      logic [RANK_W-1:0] r;
      unique case (b)
         ASCII_A: r = RANK_A;
         ASCII_C: r = RANK_C;
         ASCII_G: r = RANK_G;
         ASCII_T: r = RANK_T;
         default: r = RANK_N;
      endcase
      return r;
   endfunction

   // n packs as a
   function automatic logic [CODE_W-1:0] rank_code(input logic [RANK_W-1:0] r);
      logic [CODE_W-1:0] c;
      unique case (r)
         RANK_C:  c = CODE_C;
         RANK_G:  c = CODE_G;
         RANK_T:  c = CODE_T;
         default: c = CODE_A;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wms_req_if.sv =====
// request channel carrying one sequence byte per transfer
`default_nettype none

interface wms_req_if;
   import wms_pkg::*;

   logic              valid;
   logic              ready;
   logic [BASE_W-1:0] base;
   logic              seq_start;

   modport source (output valid, output base, output seq_start, input ready);
   modport sink   (input valid, input base, input seq_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/wms_rsp_if.sv =====
// response channel carrying one minimizer per transfer
`default_nettype none

interface wms_rsp_if;
   import wms_pkg::*;

   logic              valid;
   logic              ready;
   logic [KMER_W-1:0] min_kmer;
   logic [POS_W-1:0]  min_pos;
   logic              kmer_valid;

   modport source (output valid, output min_kmer, output min_pos, output kmer_valid,
                   input ready);
   modport sink   (input valid, input min_kmer, input min_pos, input kmer_valid,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/wms_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module wms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

// ===== rtl/wms_queue.sv =====
// small fifo of scan jobs between front and back
`default_nettype none

module wms_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic [AW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end else begin
         // both or neither, count holds
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end
endmodule

`default_nettype wire

// ===== rtl/wms_front.sv =====
// front end: takes bytes, builds k-mer keys, fills the ring and queues scan jobs
`default_nettype none

module wms_front #(
   parameter int MAX_K   = 21,
   parameter int MAX_W   = 64,
   parameter int RING_AW = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   wms_req_if.sink                                req,
   input  wire logic                              hist_clear,
   input  wire logic [$clog2(MAX_K+1)-1:0]        kmer_length,
   input  wire logic [$clog2(MAX_W+1)-1:0]        window_size,
   input  wire logic [3*MAX_K-1:0]                key_mask,
   input  wire logic                              job_full,
   input  wire logic                              jobs_drained,
   output logic                                   job_push,
   output logic      [RING_AW-1:0]                job_slot,
   output logic                                   ram_we,
   output logic      [RING_AW-1:0]                ram_waddr,
   output logic      [3*MAX_K+wms_pkg::POS_W-1:0] ram_wdata
);
   import wms_pkg::*;

   localparam int KEY_W  = 3 * MAX_K;
   localparam int HELD_W = $clog2(MAX_W + 1);

   logic [KEY_W-1:0]   recent_ff, recent_in, recent_base;
   logic [POS_W-1:0]   seen_ff, seen_in, seen_base;
   logic [HELD_W-1:0]  held_ff, held_in, held_base;
   logic [RING_AW-1:0] wptr_ff, wptr_in;
   logic               can_take;
   logic               accept;
   logic               kmer_done;

   // a new sequence waits until every queued scan has read its window, so its
   // partial window cannot overwrite ring entries that are still to be scanned
   assign can_take  = !job_full && (!req.seq_start || jobs_drained);
   assign req.ready = can_take;
   assign accept    = req.valid && can_take;

   always_comb begin
      recent_in   = recent_ff;
      seen_in     = seen_ff;
      held_in     = held_ff;
      wptr_in     = wptr_ff;
      kmer_done   = 1'b0;
      job_push    = 1'b0;
      recent_base = req.seq_start ? '0 : recent_ff;
      seen_base   = req.seq_start ? '0 : seen_ff;
      held_base   = req.seq_start ? '0 : held_ff;
      priority if (hist_clear) begin
         recent_in = '0;
         seen_in   = '0;
         held_in   = '0;
      end else if (accept) begin
         recent_in = (recent_base << 3) | KEY_W'(base_rank(req.base));
         seen_in   = (seen_base == '1) ? seen_base : seen_base + 1'b1;
         held_in   = held_base;
         kmer_done = (seen_in >= POS_W'(kmer_length));
         if (kmer_done) begin
            wptr_in  = wptr_ff + 1'b1;
            held_in  = (held_base == HELD_W'(MAX_W)) ? held_base : held_base + 1'b1;
            job_push = (held_in >= window_size);
         end
      end else begin
         // no transfer, history holds
         recent_in = recent_ff;
      end
   end

   assign ram_we    = kmer_done;
   assign ram_waddr = wptr_ff;
   assign ram_wdata = {recent_in & key_mask, seen_in - POS_W'(kmer_length)};
   assign job_slot  = wptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         seen_ff   <= '0;
         held_ff   <= '0;
         wptr_ff   <= '0;
      end else begin
         recent_ff <= recent_in;
         seen_ff   <= seen_in;
         held_ff   <= held_in;
         wptr_ff   <= wptr_in;
      end
   end

   a_push_has_write: assert property (@(posedge clock) disable iff (reset)
      job_push |-> ram_we)
      else $error("scan job queued without a ring write");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_W'(MAX_W))
      else $error("held k-mer count above window capacity");

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req.seq_start && !hist_clear) |=> (seen_ff == POS_W'(1)))
      else $error("sequence start did not restart the byte count");
endmodule

`default_nettype wire

// ===== rtl/wms_back.sv =====
// back end: rescans one window from the ring and registers the minimizer
`default_nettype none

module wms_back #(
   parameter int MAX_K   = 21,
   parameter int MAX_W   = 64,
   parameter int RING_AW = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [$clog2(MAX_W+1)-1:0]        window_size,
   input  wire logic                              job_empty,
   input  wire logic [RING_AW-1:0]                job_slot,
   output logic                                   job_pop,
   output logic                                   scan_busy,
   output logic                                   ram_re,
   output logic      [RING_AW-1:0]                ram_raddr,
   input  wire logic [3*MAX_K+wms_pkg::POS_W-1:0] ram_rdata,
   wms_rsp_if.source                              rsp
);
   import wms_pkg::*;

   localparam int KEY_W = 3 * MAX_K;
   localparam int WW    = $clog2(MAX_W + 1);

   scan_state_type     state_ff, state_in;
   logic [RING_AW-1:0] addr_ff, addr_in;
   logic [WW-1:0]      issue_left_ff, issue_left_in;
   logic [WW-1:0]      cmp_left_ff, cmp_left_in;
   logic               pend_ff, pend_in;
   logic               first_ff, first_in;
   logic [KEY_W-1:0]   best_key_ff, best_key_in;
   logic [POS_W-1:0]   best_pos_ff, best_pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KMER_W-1:0]  kmer_ff, kmer_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               kval_ff, kval_in;
   logic [KEY_W-1:0]   rd_key;
   logic [POS_W-1:0]   rd_pos;
   logic [KMER_W-1:0]  packed_kmer;
   logic               packed_ok;
   logic               out_free;

   assign rd_key    = ram_rdata[POS_W +: KEY_W];
   assign rd_pos    = ram_rdata[POS_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign ram_raddr = addr_ff;
   // ring reads of the current job still outstanding
   assign scan_busy = (state_ff == SCAN_RUN);

   // per base: key digit to two-bit code, masked digits are a and never n
   always_comb begin
      packed_kmer = '0;
      packed_ok   = 1'b1;
      for (int j = 0; j < MAX_K; j++) begin
         packed_kmer[2*j +: 2] = rank_code(best_key_ff[3*j +: 3]);
         if (best_key_ff[3*j +: 3] == RANK_N) begin
            packed_ok = 1'b0;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_left_in = issue_left_ff;
      cmp_left_in   = cmp_left_ff;
      pend_in       = 1'b0;
      first_in      = first_ff;
      best_key_in   = best_key_ff;
      best_pos_in   = best_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      kmer_in       = kmer_ff;
      pos_in        = pos_ff;
      kval_in       = kval_ff;
      job_pop       = 1'b0;
      ram_re        = 1'b0;
      unique case (state_ff)
         SCAN_IDLE: begin
            if (!job_empty) begin
               job_pop       = 1'b1;
               // oldest entry of the window first so ties keep the earliest
               addr_in       = job_slot - RING_AW'(window_size) + 1'b1;
               issue_left_in = window_size;
               cmp_left_in   = window_size;
               first_in      = 1'b1;
               state_in      = SCAN_RUN;
            end
         end
         SCAN_RUN: begin
            if (issue_left_ff != '0) begin
               ram_re        = 1'b1;
               addr_in       = addr_ff + 1'b1;
               issue_left_in = issue_left_ff - 1'b1;
               pend_in       = 1'b1;
            end
            if (pend_ff) begin
               first_in    = 1'b0;
               cmp_left_in = cmp_left_ff - 1'b1;
               if (first_ff || (rd_key < best_key_ff)) begin
                  best_key_in = rd_key;
                  best_pos_in = rd_pos;
               end
               if (cmp_left_ff == WW'(1)) begin
                  state_in = SCAN_LOAD;
               end
            end
         end
         SCAN_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kmer_in      = packed_kmer;
               pos_in       = best_pos_ff;
               kval_in      = packed_ok;
               state_in     = SCAN_IDLE;
            end
         end
         default: state_in = SCAN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCAN_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      issue_left_ff <= issue_left_in;
      cmp_left_ff   <= cmp_left_in;
      first_ff      <= first_in;
      best_key_ff   <= best_key_in;
      best_pos_ff   <= best_pos_in;
      kmer_ff       <= kmer_in;
      pos_ff        <= pos_in;
      kval_ff       <= kval_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.min_kmer   = kmer_ff;
   assign rsp.min_pos    = pos_ff;
   assign rsp.kmer_valid = kval_ff;

   a_pend_has_compare: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN_RUN && pend_ff) |-> (cmp_left_ff != '0))
      else $error("read returned with no compare left");

   a_issue_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN_RUN) |-> (issue_left_ff <= cmp_left_ff))
      else $error("more reads outstanding than compares");

   a_result_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == SCAN_LOAD))
      else $error("result raised outside the load step");
endmodule

`default_nettype wire

// ===== rtl/window_minimizer_select.sv =====
// top level of the streaming (w,k) lexicographic minimizer selector
//
//   channel   direction  transfer when       payload
//   req_chan  in         valid && ready      base[7:0], seq_start
//   rsp_chan  out        valid && ready      min_kmer[41:0], min_pos[31:0], kmer_valid
//   csr_*     in         csr_we              csr_index[0], csr_wdata[6:0]
//
// the front registers each byte into the k-mer history; a byte that completes a full
// window queues a scan job, and the back rescans it through one ram read port, one key
// compare per cycle, so the result rate is set by the scan loop. the front keeps taking
// bytes while fewer than four jobs wait.
// reset is synchronous; no clearing pass, ring entries are only read once written.
// a stalled response holds in the output register; a seq_start byte waits for all scans
`default_nettype none

module window_minimizer_select #(
   parameter int MAX_K = 21,
   parameter int MAX_W = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   wms_req_if.sink                                 req_chan,
   wms_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [wms_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [wms_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wms_pkg::*;

   localparam int KEY_W       = 3 * MAX_K;
   localparam int KW          = $clog2(MAX_K + 1);
   localparam int WW          = $clog2(MAX_W + 1);
   localparam int ENTRY_W     = KEY_W + POS_W;
   localparam int QUEUE_DEPTH = 4;
   // room for the window in scan, a new sequence's partial window and queued jobs
   localparam int RING_DEPTH  = 2 ** $clog2(2 * MAX_W + QUEUE_DEPTH + 2);
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int K_RESET     = (MAX_K < 21) ? MAX_K : 21;
   localparam int W_RESET     = (MAX_W < 10) ? MAX_W : 10;

   // effective (clamped) configuration
   logic [KW-1:0]        klen_ff, klen_in;
   logic [WW-1:0]        wsize_ff, wsize_in;
   logic [KLEN_W-1:0]    klen_raw;
   logic [WSIZE_W-1:0]   wsize_raw;
   logic [KEY_W-1:0]     key_mask;

   // front to queue and ring
   logic                 job_push;
   logic [RING_AW-1:0]   push_slot;
   logic                 job_full;
   logic                 job_empty;
   logic                 job_pop;
   logic [RING_AW-1:0]   pop_slot;
   logic                 scan_busy;
   logic                 jobs_drained;
   logic                 ram_we;
   logic [RING_AW-1:0]   ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic                 ram_re;
   logic [RING_AW-1:0]   ram_raddr;
   logic [ENTRY_W-1:0]   ram_rdata;

   assign klen_raw  = csr_wdata[KLEN_W-1:0];
   assign wsize_raw = csr_wdata[WSIZE_W-1:0];

   // no queued job and no ring read in progress
   assign jobs_drained = job_empty && !scan_busy;

   // register writes clamp out-of-range values to the legal span
   always_comb begin
      klen_in  = klen_ff;
      wsize_in = wsize_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KMER_LENGTH: begin
               priority if (klen_raw == '0) begin
                  klen_in = KW'(1);
               end else if (int'(klen_raw) > MAX_K) begin
                  klen_in = KW'(MAX_K);
               end else begin
                  klen_in = KW'(klen_raw);
               end
            end
            CSR_WINDOW_SIZE: begin
               priority if (wsize_raw == '0) begin
                  wsize_in = WW'(1);
               end else if (int'(wsize_raw) > MAX_W) begin
                  wsize_in = WW'(MAX_W);
               end else begin
                  wsize_in = WW'(wsize_raw);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff  <= KW'(K_RESET);
         wsize_ff <= WW'(W_RESET);
      end else begin
         klen_ff  <= klen_in;
         wsize_ff <= wsize_in;
      end
   end

   // keep the newest klen base ranks of the history
   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         key_mask[3*j +: 3] = (j < int'(klen_ff)) ? 3'b111 : 3'b000;
      end
   end

   wms_front #(
      .MAX_K   (MAX_K),
      .MAX_W   (MAX_W),
      .RING_AW (RING_AW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .hist_clear   (csr_we),
      .kmer_length  (klen_ff),
      .window_size  (wsize_ff),
      .key_mask     (key_mask),
      .job_full     (job_full),
      .jobs_drained (jobs_drained),
      .job_push     (job_push),
      .job_slot     (push_slot),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata)
   );

   // ring of k-mer keys and start positions
   wms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // scan jobs: ring slot of the newest k-mer of each full window
   wms_queue #(
      .WIDTH (RING_AW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_slot),
      .pop       (job_pop),
      .pop_data  (pop_slot),
      .full      (job_full),
      .empty     (job_empty)
   );

   wms_back #(
      .MAX_K   (MAX_K),
      .MAX_W   (MAX_W),
      .RING_AW (RING_AW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .window_size (wsize_ff),
      .job_empty   (job_empty),
      .job_slot    (pop_slot),
      .job_pop     (job_pop),
      .scan_busy   (scan_busy),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .rsp         (rsp_chan)
   );
endmodule

`default_nettype wire

// ===== tb/sv/window_minimizer_select_checker.sv =====
// monitor, minimizer predictor and result comparison for window_minimizer_select
`timescale 1ns / 100ps

module window_minimizer_select_checker #(
   parameter int MAX_K = 21,
   parameter int MAX_W = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   wms_req_if                                  req_mon,
   wms_rsp_if                                  rsp_mon,
   input  wire logic                           csr_we,
   input  wire logic [wms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wms_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                  fail_count,
   output int                                  pending_results
);
   import wms_pkg::*;

   localparam int KEY_W = RANK_W * MAX_K;
   localparam logic [KLEN_W-1:0]  KLEN_RESET  = 5'd21;
   localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd10;

   typedef struct packed {
      logic [KMER_W-1:0] kmer;
      logic [POS_W-1:0]  pos;
      logic              acgt_only;
   } minimizer_type;

   logic [KLEN_W-1:0]  kmer_length_q;
   logic [WSIZE_W-1:0] window_size_q;
   logic [KEY_W-1:0]   rank_history;
   logic [KEY_W-1:0]   ring_key [MAX_W];
   logic [POS_W-1:0]   ring_start [MAX_W];
   int unsigned        ring_next;
   int unsigned        ring_count;
   logic [POS_W-1:0]   bases_in_seq;
   minimizer_type      expected_minimizers [$];

   function automatic logic [RANK_W-1:0] rank_of(input logic [BASE_W-1:0] b);
      case (b)
         ASCII_A: return RANK_A;
         ASCII_C: return RANK_C;
         ASCII_G: return RANK_G;
         ASCII_T: return RANK_T;
         default: return RANK_N;
      endcase
   endfunction

   task automatic clear_history();
      rank_history = '0;
      ring_next    = 0;
      ring_count   = 0;
      bases_in_seq = '0;
   endtask

   // one byte in, zero or one minimizer queued
   task automatic take_base(input logic [BASE_W-1:0] b, input logic start);
      int unsigned       k;
      int unsigned       w;
      int unsigned       slot;
      logic [KEY_W-1:0]  mask;
      logic [KEY_W-1:0]  best_key;
      logic [POS_W-1:0]  best_pos;
      logic [RANK_W-1:0] r;
      logic [CODE_W-1:0] code;
      minimizer_type     m;
      k = (kmer_length_q == 0) ? 1 : (kmer_length_q > MAX_K) ? MAX_K : kmer_length_q;
      w = (window_size_q == 0) ? 1 : (window_size_q > MAX_W) ? MAX_W : window_size_q;
      mask = '0;
      for (int i = 0; i < RANK_W * k; i++) mask[i] = 1'b1;
      if (start) clear_history();
      rank_history = {rank_history[KEY_W-RANK_W-1:0], rank_of(b)};
      if (bases_in_seq != '1) bases_in_seq++;
      if (bases_in_seq < k) return;
      ring_key[ring_next]   = rank_history & mask;
      ring_start[ring_next] = bases_in_seq - k;
      ring_next = (ring_next + 1 == MAX_W) ? 0 : ring_next + 1;
      if (ring_count < MAX_W) ring_count++;
      if (ring_count < w) return;
      // oldest entry first so that ties keep the earliest start
      slot     = (ring_next + MAX_W - w) % MAX_W;
      best_key = ring_key[slot];
      best_pos = ring_start[slot];
      for (int i = 1; i < w; i++) begin
         slot = (slot + 1 == MAX_W) ? 0 : slot + 1;
         if (ring_key[slot] < best_key) begin
            best_key = ring_key[slot];
            best_pos = ring_start[slot];
         end
      end
      m.kmer      = '0;
      m.pos       = best_pos;
      m.acgt_only = 1'b1;
      for (int i = 0; i < k; i++) begin
         r = best_key[RANK_W*(k-1-i) +: RANK_W];
         case (r)
            RANK_C: code = CODE_C;
            RANK_G: code = CODE_G;
            RANK_T: code = CODE_T;
            RANK_N: begin
               code        = CODE_A;
               m.acgt_only = 1'b0;
            end
            default: code = CODE_A;
         endcase
         m.kmer = {m.kmer[KMER_W-CODE_W-1:0], code};
      end
      expected_minimizers = {expected_minimizers, m};
   endtask

   always @(posedge clock) begin
      minimizer_type want;
      if (reset) begin
         kmer_length_q = KLEN_RESET;
         window_size_q = WSIZE_RESET;
         clear_history();
         expected_minimizers.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KMER_LENGTH: kmer_length_q = csr_wdata[KLEN_W-1:0];
               CSR_WINDOW_SIZE: window_size_q = csr_wdata[WSIZE_W-1:0];
               default: ;
            endcase
            clear_history();
         end
         if (req_mon.valid && req_mon.ready) take_base(req_mon.base, req_mon.seq_start);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_minimizers.size() == 0) begin
               $error("unexpected result: min_kmer %h min_pos %0d kmer_valid %b",
                      rsp_mon.min_kmer, rsp_mon.min_pos, rsp_mon.kmer_valid);
               fail_count++;
            end else begin
               want = expected_minimizers.pop_front();
               if (rsp_mon.min_kmer !== want.kmer) begin
                  $error("min_kmer: expected %h, actual %h", want.kmer, rsp_mon.min_kmer);
                  fail_count++;
               end
               if (rsp_mon.min_pos !== want.pos) begin
                  $error("min_pos: expected %0d, actual %0d", want.pos, rsp_mon.min_pos);
                  fail_count++;
               end
               if (rsp_mon.kmer_valid !== want.acgt_only) begin
                  $error("kmer_valid: expected %b, actual %b", want.acgt_only,
                         rsp_mon.kmer_valid);
                  fail_count++;
               end
            end
         end
      end
      pending_results = expected_minimizers.size();
   end

endmodule

// ===== tb/sv/window_minimizer_select_test.sv =====
// testbench top: clock, reset, stimulus, receiver stalls and verdict for window_minimizer_select
`timescale 1ns / 100ps

module window_minimizer_select_test;
   import wms_pkg::*;

   // generous cap: worst case per byte is a long gap, a full 64-entry scan and a long stall
   localparam int LIMIT_CYCLES  = 1_500_000;
   // quiet time before a register write and at the end, covers a full scan plus queued jobs
   localparam int SETTLE_CYCLES = 200;
   // the one long receiver hold-off
   localparam int HOLD_CYCLES   = 600;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_results;
   bit                    idling;        // random gaps and stalls on when set
   bit                    hold_request;  // asks the receiver for one long hold-off
   logic [BASE_W-1:0]     last_base;

   wms_req_if req_chan ();
   wms_rsp_if rsp_chan ();

   window_minimizer_select DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   window_minimizer_select_checker minimizer_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 70);
   endfunction

   // mostly clean bases, some runs of one base for ties, some n and arbitrary bytes
   function automatic logic [BASE_W-1:0] next_base();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 68) begin
         case ($urandom_range(0, 3))
            0:       last_base = ASCII_A;
            1:       last_base = ASCII_C;
            2:       last_base = ASCII_G;
            default: last_base = ASCII_T;
         endcase
      end else if (roll >= 82 && roll < 90) begin
         last_base = "N";
      end else if (roll >= 90) begin
         last_base = BASE_W'($urandom_range(0, 255));
      end
      // the rest repeats the previous byte
      return last_base;
   endfunction

   // offer one byte, return at the falling edge after its transfer; valid stays high
   // so that a following byte with no gap goes out back to back
   task automatic send_byte(input logic [BASE_W-1:0] b, input logic start);
      int gap;
      gap = idling ? pick_idle_span() : 0;
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.base      = b;
      req_chan.seq_start = start;
      req_chan.valid     = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // a new sequence: first character carries seq_start
   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], i == 0);
   endtask

   // register write only once every expected result is out and the block has gone quiet
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      req_chan.valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // one setting of both registers, then a run of random bytes
   task automatic run_phase(input logic [CSR_DATA_W-1:0] klen_data,
                            input logic [CSR_DATA_W-1:0] wsize_data,
                            input int n_items, input bit with_idling, input bit with_hold);
      int   span;
      logic start;
      write_reg(CSR_KMER_LENGTH, klen_data);
      write_reg(CSR_WINDOW_SIZE, wsize_data);
      idling = with_idling;
      // restarts rare enough that full windows still form
      span = 40 + 2 * (klen_data[KLEN_W-1:0] + wsize_data);
      for (int i = 0; i < n_items; i++) begin
         if (with_hold && i == n_items / 3) hold_request = 1'b1;
         start = (i == 0) ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, span) == 0);
         send_byte(next_base(), start);
      end
      req_chan.valid = 1'b0;
   endtask

   // receiver: always ready, random stalls, or the one long hold-off
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            // sender keeps offering bytes while results back up into the block
            hold_request   = 1'b0;
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!idling) begin
            rsp_chan.ready = 1'b1;
            @(negedge clock);
         end else begin
            stall = pick_idle_span();
            if (stall > 0) begin
               rsp_chan.ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_chan.ready = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   // watchdog
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int klen_data;
      int wsize_data;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_KMER_LENGTH;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.base      = '0;
      req_chan.seq_start = 1'b0;
      idling             = 1'b0;
      hold_request       = 1'b0;
      last_base          = ASCII_A;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // k=1, w=1: every byte is its own minimizer; byte extremes and non-acgt bytes
      write_reg(CSR_KMER_LENGTH, 7'd1);
      write_reg(CSR_WINDOW_SIZE, 7'd1);
      idling = 1'b1;
      send_byte(ASCII_A, 1'b1);
      send_byte(ASCII_C, 1'b0);
      send_byte(ASCII_G, 1'b0);
      send_byte(ASCII_T, 1'b0);
      send_byte("N", 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte("a", 1'b0);
      req_chan.valid = 1'b0;

      // k=2, w=3: equal k-mers go to the earliest, partial windows give nothing,
      // a restart mid-stream, and n inside the winning k-mer
      write_reg(CSR_KMER_LENGTH, 7'd2);
      write_reg(CSR_WINDOW_SIZE, 7'd3);
      send_text("ACACAC");
      send_text("TTTTNAA");
      req_chan.valid = 1'b0;

      // largest setting
      run_phase(7'd21, 7'd64, 150, 1'b1, 1'b0);
      // zero in both registers acts as one; long receiver hold-off, no idling otherwise
      run_phase(7'h60, 7'd0, 100, 1'b0, 1'b1);
      // all ones: both registers above their maximum
      run_phase(7'h7F, 7'h7F, 120, 1'b1, 1'b0);
      // random settings, small windows most of the time, upper data bits random
      for (int p = 0; p < 8; p++) begin
         klen_data  = ($urandom_range(0, 3) << KLEN_W) | $urandom_range(0, 24);
         wsize_data = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 12)
                                                   : $urandom_range(0, 127);
         run_phase(CSR_DATA_W'(klen_data), CSR_DATA_W'(wsize_data), 100, p[0], 1'b0);
      end

      // drain, then a quiet stretch to catch stray results
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
